>>> design/edcs_pkg.sv
package edcs_pkg;

    // Number of motor outputs that a special command may address.
    localparam int MOTOR_COUNT = 8;
    localparam logic [7:0] MOTOR_BITS =
        (MOTOR_COUNT >= 8) ? 8'hFF : 8'((1 << MOTOR_COUNT) - 1);

    // Fixed zero-throttle gap between the direction and the save command.
    localparam logic [31:0] GAP_USEC = 32'd30000;

    // Special command codes sent to the motor drivers.
    localparam logic [5:0] CODE_NONE     = 6'd0;
    localparam logic [5:0] CODE_NORMAL   = 6'd7;
    localparam logic [5:0] CODE_REVERSED = 6'd8;
    localparam logic [5:0] CODE_SAVE     = 6'd12;

    // Sequence phases.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_PRE  = 3'd1,
        PH_DIR  = 3'd2,
        PH_GAP  = 3'd3,
        PH_SAVE = 3'd4,
        PH_POST = 3'd5
    } t_phase;

    // Events reported with each result item.
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_DONE  = 2'd2,
        EV_ABORT = 2'd3
    } t_event;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ALLOWED_SOURCE    = 3'd0,
        CFG_EXPECTED_VERSION  = 3'd1,
        CFG_OP_NORMAL_CODE    = 3'd2,
        CFG_OP_REVERSED_CODE  = 3'd3,
        CFG_CONFIRM_VALUE     = 3'd4,
        CFG_PRE_HOLD_USEC     = 3'd5,
        CFG_SPECIAL_HOLD_USEC = 3'd6,
        CFG_POST_HOLD_USEC    = 3'd7
    } t_cfg_idx;

    // Input mode codes.
    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_POLL   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [63:0] stamp_us;
        logic [7:0]  source_node;
        logic [7:0]  proto_version;
        logic [7:0]  operation;
        logic [7:0]  out_sel;
        logic [15:0] confirmation;
        logic [15:0] req_tag;
        logic        outputs_stopped;
        logic        special_accepted;
    } t_in_item;

    typedef struct packed {
        logic        submit_accepted;
        logic        force_stop;
        logic        load_special;
        logic [5:0]  special_code;
        logic [7:0]  special_mask;
        logic        busy_res;
        logic [1:0]  event_res;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  allowed_source;
        logic [7:0]  expected_version;
        logic [7:0]  op_normal_code;
        logic [7:0]  op_reversed_code;
        logic [15:0] confirm_value;
        logic [31:0] pre_hold_usec;
        logic [31:0] special_hold_usec;
        logic [31:0] post_hold_usec;
    } t_cfg;

    // Register values after reset.
    localparam t_cfg CFG_RESET = '{
        allowed_source:    8'd0,
        expected_version:  8'd1,
        op_normal_code:    8'd0,
        op_reversed_code:  8'd1,
        confirm_value:     16'hA55A,
        pre_hold_usec:     32'd1000000,
        special_hold_usec: 32'd30000,
        post_hold_usec:    32'd500000
    };

endpackage

>>> design/edcs_stream_if.sv
// Valid/ready channel carrying one item of type T.
interface edcs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/esc_direction_change_sequencer_core.sv
// Direction-change sequencer: takes submit and poll-tick items on i_in and returns exactly
// one result item per input item on o_out, in order. One item is accepted every clock
// cycle when the output side keeps up; each item passes through an input register, the
// single-step sequencer logic (a 64-bit elapsed-time subtract and compare sets the path),
// and a result register. The result is presented on o_out once its item has passed the input
// register and the sequencer step, and it leaves when o_out.ready is high. A stalled result lets
// one more item into the input register and then keeps i_in.ready low until the result is taken.
// Configuration registers are written through i_cfg_we/i_cfg_addr/i_cfg_wdata; the user must
// write them only while no item is in flight, as the block itself does not enforce this.
module esc_direction_change_sequencer_core
    import edcs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    edcs_stream_if.sink   i_in,
    edcs_stream_if.source o_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata
);

    t_cfg      cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item step_result;
    logic      advance;

    edcs_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // The held item steps when the result register is free or being drained.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    edcs_sequencer u_sequencer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= step_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !advance)
        else $error("result overwritten while stalled");

    // A held item that cannot step keeps the input side closed.
    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> !i_in.ready)
        else $error("input accepted while an item is held");

    // A stepped item always produces a result in the next cycle.
    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("stepped item produced no result");

endmodule

>>> design/edcs_cfg_regs.sv
module edcs_cfg_regs
    import edcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register writes, each truncated to the width of its register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_ALLOWED_SOURCE:    r_cfg.allowed_source    <= i_cfg_wdata[7:0];
                CFG_EXPECTED_VERSION:  r_cfg.expected_version  <= i_cfg_wdata[7:0];
                CFG_OP_NORMAL_CODE:    r_cfg.op_normal_code    <= i_cfg_wdata[7:0];
                CFG_OP_REVERSED_CODE:  r_cfg.op_reversed_code  <= i_cfg_wdata[7:0];
                CFG_CONFIRM_VALUE:     r_cfg.confirm_value     <= i_cfg_wdata[15:0];
                CFG_PRE_HOLD_USEC:     r_cfg.pre_hold_usec     <= i_cfg_wdata;
                CFG_SPECIAL_HOLD_USEC: r_cfg.special_hold_usec <= i_cfg_wdata;
                CFG_POST_HOLD_USEC:    r_cfg.post_hold_usec    <= i_cfg_wdata;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/edcs_sequencer.sv
module edcs_sequencer
    import edcs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_phase      r_phase, n_phase;
    logic        r_pending, n_pending;
    logic [63:0] r_start, n_start;
    logic        r_want_rev, n_want_rev;
    logic [7:0]  r_mask, n_mask;
    logic        r_have_id, n_have_id;
    logic [15:0] r_last_id, n_last_id;
    logic [5:0]  r_active, n_active;

    logic        is_poll;
    logic        submit_ok;
    logic [31:0] hold_dur;
    logic [63:0] span;
    logic        elapsed;
    logic        force_stop;
    logic        load_special;
    t_event      event_code;

    assign is_poll = (i_item.mode == MODE_POLL);

    // Submit checks; the order only matters for diagnosis, all must pass.
    assign submit_ok = (i_item.source_node == i_cfg.allowed_source)
                    && (i_item.proto_version == i_cfg.expected_version)
                    && ((i_item.operation == i_cfg.op_normal_code)
                        || (i_item.operation == i_cfg.op_reversed_code))
                    && (i_item.out_sel != 8'd0)
                    && (i_item.confirmation == i_cfg.confirm_value)
                    && !r_pending
                    && !(r_have_id && (i_item.req_tag == r_last_id))
                    && i_item.outputs_stopped;

    // Hold time of the current phase.
    always_comb begin
        unique case (r_phase)
            PH_PRE:          hold_dur = i_cfg.pre_hold_usec;
            PH_DIR, PH_SAVE: hold_dur = i_cfg.special_hold_usec;
            PH_GAP:          hold_dur = GAP_USEC;
            PH_POST:         hold_dur = i_cfg.post_hold_usec;
            default:         hold_dur = 32'd0;
        endcase
    end

    // Time in the current phase, modulo 2^64.
    assign span    = i_item.stamp_us - r_start;
    assign elapsed = (span >= {32'd0, hold_dur});

    // Next state.
    always_comb begin
        n_phase    = r_phase;
        n_pending  = r_pending;
        n_start    = r_start;
        n_want_rev = r_want_rev;
        n_mask     = r_mask;
        n_have_id  = r_have_id;
        n_last_id  = r_last_id;
        n_active   = r_active;
        if (!is_poll) begin
            if (submit_ok) begin
                n_want_rev = (i_item.operation != i_cfg.op_normal_code);
                n_mask     = i_item.out_sel;
                n_last_id  = i_item.req_tag;
                n_have_id  = 1'b1;
                n_pending  = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_pending) begin
                        n_active = CODE_NONE;
                        n_phase  = PH_PRE;
                        n_start  = i_item.stamp_us;
                    end
                end
                PH_PRE, PH_GAP: begin
                    if (elapsed) begin
                        if (!i_item.special_accepted) begin
                            n_active  = CODE_NONE;
                            n_pending = 1'b0;
                            n_phase   = PH_IDLE;
                        end else begin
                            if (r_phase == PH_PRE) begin
                                n_active = r_want_rev ? CODE_REVERSED : CODE_NORMAL;
                                n_phase  = PH_DIR;
                            end else begin
                                n_active = CODE_SAVE;
                                n_phase  = PH_SAVE;
                            end
                            n_start = i_item.stamp_us;
                        end
                    end
                end
                PH_DIR, PH_SAVE: begin
                    if (elapsed) begin
                        n_active = CODE_NONE;
                        n_phase  = (r_phase == PH_DIR) ? PH_GAP : PH_POST;
                        n_start  = i_item.stamp_us;
                    end
                end
                PH_POST: begin
                    if (elapsed) begin
                        n_pending = 1'b0;
                        n_phase   = PH_IDLE;
                        n_start   = i_item.stamp_us;
                    end
                end
                default: begin
                    // An unknown phase code aborts the sequence.
                    n_active  = CODE_NONE;
                    n_pending = 1'b0;
                    n_phase   = PH_IDLE;
                end
            endcase
        end
    end

    // Per-step strobes and event.
    always_comb begin
        force_stop   = 1'b0;
        load_special = 1'b0;
        event_code   = EV_NONE;
        if (is_poll) begin
            unique case (r_phase)
                PH_IDLE: begin
                    force_stop = r_pending;
                    event_code = r_pending ? EV_START : EV_NONE;
                end
                PH_PRE, PH_GAP: begin
                    force_stop = 1'b1;
                    if (elapsed) begin
                        if (!i_item.special_accepted) begin
                            event_code = EV_ABORT;
                        end else begin
                            load_special = 1'b1;
                        end
                    end
                end
                PH_DIR, PH_SAVE: begin
                    force_stop = elapsed;
                end
                PH_POST: begin
                    force_stop = 1'b1;
                    event_code = elapsed ? EV_DONE : EV_NONE;
                end
                default: begin
                    force_stop = 1'b1;
                    event_code = EV_ABORT;
                end
            endcase
        end
    end

    // Result item reflects the state after the step.
    always_comb begin
        o_result.submit_accepted = !is_poll && submit_ok;
        o_result.force_stop      = force_stop;
        o_result.load_special    = load_special;
        o_result.special_code    = n_active;
        o_result.special_mask    = (n_active != CODE_NONE) ? (n_mask & MOTOR_BITS) : 8'd0;
        o_result.busy_res        = n_pending || (n_phase != PH_IDLE);
        o_result.event_res       = event_code;
    end

    // State update, one item per step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pending  <= 1'b0;
            r_start    <= 64'd0;
            r_want_rev <= 1'b0;
            r_mask     <= 8'd0;
            r_have_id  <= 1'b0;
            r_last_id  <= 16'd0;
            r_active   <= CODE_NONE;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_pending  <= n_pending;
            r_start    <= n_start;
            r_want_rev <= n_want_rev;
            r_mask     <= n_mask;
            r_have_id  <= n_have_id;
            r_last_id  <= n_last_id;
            r_active   <= n_active;
        end
    end

    // The sequence only runs while a request is pending.
    a_phase_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> r_pending)
        else $error("sequence active without a pending request");

    // A load always leaves the block holding a special command phase.
    a_load_enters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.load_special) |=> ((r_phase == PH_DIR) || (r_phase == PH_SAVE)))
        else $error("special command load did not enter a hold phase");

    // An accepted submit marks the request pending.
    a_submit_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.submit_accepted) |=> r_pending)
        else $error("accepted submit did not set pending");

    // A start event moves the sequence into the first zero hold.
    a_start_enters_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (o_result.event_res == EV_START)) |=> (r_phase == PH_PRE))
        else $error("start event without entering the zero hold");

endmodule
